// ===== rtl/core/timestamp_arithmetic_unit_defines.svh =====
// assertion macros for the timestamp arithmetic unit
`ifndef TIMESTAMP_ARITHMETIC_UNIT_DEFINES_SVH
`define TIMESTAMP_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TSA_ASSERT_HOLD(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("timestamp unit check failed");
`define TSA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timestamp unit check failed");
`else
`define TSA_ASSERT_HOLD(lbl, cond)
`define TSA_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/tsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

    localparam int MICRO_W = 20;
    localparam logic [MICRO_W-1:0] MICROS_PER_SEC = 20'd1000000;
    // quotient bits per stage of the split by one second
    localparam int SPLIT_BITS = 4;
    // factor bits per stage of the multiplier
    localparam int MUL_CHUNK = 8;

    typedef enum logic [2:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_CMP = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  neg;
        logic  lt;
        logic  eq;
        logic  gt;
        logic  dz;
    } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsa_div #(
    parameter int MAG_W       = 69,
    parameter int FACTOR_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire tsa_pkg::ctl_t          in_ctl,
    input  wire logic [MAG_W-1:0]       in_mag,
    input  wire logic [FACTOR_BITS-1:0] in_mult,
    input  wire logic [FACTOR_BITS-1:0] in_dvs,
    output logic                        out_valid,
    output tsa_pkg::ctl_t               out_ctl,
    output logic [MAG_W-1:0]            out_quo,
    output logic [FACTOR_BITS-1:0]      out_mult
);
    import tsa_pkg::*;

    logic                   vld_reg  [1:MAG_W];
    ctl_t                   ctl_reg  [1:MAG_W];
    logic [MAG_W-1:0]       wrk_reg  [1:MAG_W];
    logic [FACTOR_BITS-1:0] rem_reg  [1:MAG_W];
    logic [FACTOR_BITS-1:0] dvs_reg  [1:MAG_W];
    logic [FACTOR_BITS-1:0] mult_reg [1:MAG_W];

    logic                   vld_s  [0:MAG_W];
    ctl_t                   ctl_s  [0:MAG_W];
    logic [MAG_W-1:0]       wrk_s  [0:MAG_W];
    logic [FACTOR_BITS-1:0] rem_s  [0:MAG_W];
    logic [FACTOR_BITS-1:0] dvs_s  [0:MAG_W];
    logic [FACTOR_BITS-1:0] mult_s [0:MAG_W];

    // stage views: inputs feed stage zero
    assign vld_s[0]  = in_valid;
    assign ctl_s[0]  = in_ctl;
    assign wrk_s[0]  = in_mag;
    assign rem_s[0]  = '0;
    assign dvs_s[0]  = in_dvs;
    assign mult_s[0] = in_mult;

    for (genvar v = 1; v <= MAG_W; v++) begin : g_view
        assign vld_s[v]  = vld_reg[v];
        assign ctl_s[v]  = ctl_reg[v];
        assign wrk_s[v]  = wrk_reg[v];
        assign rem_s[v]  = rem_reg[v];
        assign dvs_s[v]  = dvs_reg[v];
        assign mult_s[v] = mult_reg[v];
    end

    // one restoring step per stage, quotient bits shift in at the bottom
    for (genvar k = 0; k < MAG_W; k++) begin : g_stage
        logic [FACTOR_BITS:0]   trial;
        logic [FACTOR_BITS+1:0] diff;
        logic                   take;

        always_comb
        begin
            trial = {rem_s[k], wrk_s[k][MAG_W-1]};
            diff  = {1'b0, trial} - {2'b00, dvs_s[k]};
            take  = !diff[FACTOR_BITS+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctl_reg[k+1]  <= ctl_s[k];
                wrk_reg[k+1]  <= {wrk_s[k][MAG_W-2:0], take};
                rem_reg[k+1]  <= take ? diff[FACTOR_BITS-1:0] : trial[FACTOR_BITS-1:0];
                dvs_reg[k+1]  <= dvs_s[k];
                mult_reg[k+1] <= mult_s[k];
            end
        end
    end

    assign out_valid = vld_s[MAG_W];
    assign out_ctl   = ctl_s[MAG_W];
    assign out_quo   = wrk_s[MAG_W];
    assign out_mult  = mult_s[MAG_W];

endmodule

`default_nettype wire

// ===== rtl/core/tsa_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsa_mul #(
    parameter int MAG_W       = 69,
    parameter int FACTOR_BITS = 32,
    localparam int PW         = MAG_W + FACTOR_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire tsa_pkg::ctl_t          in_ctl,
    input  wire logic [MAG_W-1:0]       in_mag,
    input  wire logic [FACTOR_BITS-1:0] in_mult,
    output logic                        out_valid,
    output tsa_pkg::ctl_t               out_ctl,
    output logic [PW-1:0]               out_prod
);
    import tsa_pkg::*;

    localparam int NCH = (FACTOR_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MP  = NCH * MUL_CHUNK;
    localparam int AW  = MAG_W + MP;

    logic             vld_reg  [1:NCH];
    ctl_t             ctl_reg  [1:NCH];
    logic [MAG_W-1:0] mag_reg  [1:NCH];
    logic [MP-1:0]    mult_reg [1:NCH];
    logic [AW-1:0]    acc_reg  [1:NCH];

    logic             vld_s  [0:NCH];
    ctl_t             ctl_s  [0:NCH];
    logic [MAG_W-1:0] mag_s  [0:NCH];
    logic [MP-1:0]    mult_s [0:NCH];
    logic [AW-1:0]    acc_s  [0:NCH];

    assign vld_s[0]  = in_valid;
    assign ctl_s[0]  = in_ctl;
    assign mag_s[0]  = in_mag;
    assign mult_s[0] = MP'(in_mult);
    assign acc_s[0]  = '0;

    for (genvar v = 1; v <= NCH; v++) begin : g_view
        assign vld_s[v]  = vld_reg[v];
        assign ctl_s[v]  = ctl_reg[v];
        assign mag_s[v]  = mag_reg[v];
        assign mult_s[v] = mult_reg[v];
        assign acc_s[v]  = acc_reg[v];
    end

    // one factor chunk per stage, partial product shifted into place
    for (genvar k = 0; k < NCH; k++) begin : g_stage
        logic [MAG_W+MUL_CHUNK-1:0] pp;
        logic [AW-1:0]              acc_next;

        always_comb
        begin
            pp       = {{MUL_CHUNK{1'b0}}, mag_s[k]}
                     * {{MAG_W{1'b0}}, mult_s[k][k*MUL_CHUNK +: MUL_CHUNK]};
            acc_next = acc_s[k] + (AW'(pp) << (k * MUL_CHUNK));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctl_reg[k+1]  <= ctl_s[k];
                mag_reg[k+1]  <= mag_s[k];
                mult_reg[k+1] <= mult_s[k];
                acc_reg[k+1]  <= acc_next;
            end
        end
    end

    assign out_valid = vld_s[NCH];
    assign out_ctl   = ctl_s[NCH];
    assign out_prod  = acc_s[NCH][PW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/tsa_split.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsa_split #(
    parameter int PW  = 101,
    localparam int QW = ((PW + tsa_pkg::SPLIT_BITS - 1) / tsa_pkg::SPLIT_BITS)
                        * tsa_pkg::SPLIT_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire tsa_pkg::ctl_t                  in_ctl,
    input  wire logic [PW-1:0]                  in_prod,
    output logic                                out_valid,
    output tsa_pkg::ctl_t                       out_ctl,
    output logic signed [QW:0]                  out_sec,
    output logic [tsa_pkg::MICRO_W-1:0]         out_micro
);
    import tsa_pkg::*;

    localparam int NST = QW / SPLIT_BITS;

    logic               vld_reg [1:NST];
    ctl_t               ctl_reg [1:NST];
    logic [QW-1:0]      wrk_reg [1:NST];
    logic [MICRO_W-1:0] rem_reg [1:NST];

    logic               vld_s [0:NST];
    ctl_t               ctl_s [0:NST];
    logic [QW-1:0]      wrk_s [0:NST];
    logic [MICRO_W-1:0] rem_s [0:NST];

    logic               fix_vld_reg;
    ctl_t               fix_ctl_reg;
    logic signed [QW:0] fix_sec_reg;
    logic [MICRO_W-1:0] fix_us_reg;
    logic signed [QW:0] sec_next;
    logic [MICRO_W-1:0] us_next;
    logic [QW:0]        q_ext;

    assign vld_s[0] = in_valid;
    assign ctl_s[0] = in_ctl;
    assign wrk_s[0] = QW'(in_prod);
    assign rem_s[0] = '0;

    for (genvar v = 1; v <= NST; v++) begin : g_view
        assign vld_s[v] = vld_reg[v];
        assign ctl_s[v] = ctl_reg[v];
        assign wrk_s[v] = wrk_reg[v];
        assign rem_s[v] = rem_reg[v];
    end

    // long division by one second, SPLIT_BITS quotient bits per stage
    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic [QW-1:0]      w;
        logic [MICRO_W-1:0] r;
        logic [MICRO_W:0]   t;

        always_comb
        begin
            w = wrk_s[k];
            r = rem_s[k];
            t = '0;
            for (int b = 0; b < SPLIT_BITS; b++)
            begin
                t = {r, w[QW-1]};
                w = {w[QW-2:0], 1'b0};
                if (t >= {1'b0, MICROS_PER_SEC})
                begin
                    t    = t - {1'b0, MICROS_PER_SEC};
                    w[0] = 1'b1;
                end
                r = t[MICRO_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctl_reg[k+1] <= ctl_s[k];
                wrk_reg[k+1] <= w;
                rem_reg[k+1] <= r;
            end
        end
    end

    // floor correction for negative values
    always_comb
    begin
        q_ext = {1'b0, wrk_s[NST]};
        if (ctl_s[NST].neg)
        begin
            sec_next = (rem_s[NST] == '0) ? -$signed(q_ext) : $signed(~q_ext);
        end
        else
        begin
            sec_next = $signed(q_ext);
        end
        us_next = (ctl_s[NST].neg && rem_s[NST] != '0)
                ? MICROS_PER_SEC - rem_s[NST] : rem_s[NST];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            fix_vld_reg <= vld_s[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fix_ctl_reg <= ctl_s[NST];
            fix_sec_reg <= sec_next;
            fix_us_reg  <= us_next;
        end
    end

    assign out_valid = fix_vld_reg;
    assign out_ctl   = fix_ctl_reg;
    assign out_sec   = fix_sec_reg;
    assign out_micro = fix_us_reg;

endmodule

`default_nettype wire

// ===== rtl/core/timestamp_arithmetic_unit.sv =====
// channel | signals                     | beat contents
// s       | s_tvalid s_tready s_tdata   | a_seconds a_micro b_seconds b_micro factor
//         | s_tuser                     | kind
// m       | m_tvalid m_tready m_tdata   | res_seconds res_micro flags
//
// one beat accepted per cycle while s_tready is high, results leave in order
// stages, from the input register to the output register:
//   4 front stages, (SECONDS_BITS+21) divider stages, ceil(FACTOR_BITS/8) multiplier stages,
//   ceil((SECONDS_BITS+21+FACTOR_BITS)/4) split stages, then floor fix, result and output regs
// reset clears all valid bits at once, no items are in flight afterwards
// a stalled output fills a one-beat skid stage, then the whole pipeline holds
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_arithmetic_unit_defines.svh"

module timestamp_arithmetic_unit #(
    parameter int SECONDS_BITS = 48,
    parameter int FACTOR_BITS  = 32,
    localparam int IN_DW  = ((2 * SECONDS_BITS + 40 + FACTOR_BITS + 7) / 8) * 8,
    localparam int OUT_DW = ((SECONDS_BITS + 25 + 7) / 8) * 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // a_seconds, a_micro, b_seconds, b_micro, factor, zero fill
    input  wire logic [IN_DW-1:0]  s_tdata,
    // kind
    input  wire logic [2:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // res_seconds, res_micro, is_less, is_equal, is_greater, overflow, divide_by_zero, zero fill
    output logic [OUT_DW-1:0]      m_tdata
);
    import tsa_pkg::*;

    localparam int S     = SECONDS_BITS;
    localparam int F     = FACTOR_BITS;
    localparam int TW    = S + 22;
    localparam int MAG_W = S + 21;
    localparam int PW    = MAG_W + F;
    localparam int QW    = ((PW + SPLIT_BITS - 1) / SPLIT_BITS) * SPLIT_BITS;
    localparam int RW    = S + 25;
    localparam int FLG   = S + MICRO_W;

    logic en;

    // input register
    logic                  in_vld_reg;
    kind_t                 in_kind_reg;
    logic signed [S-1:0]   a_sec_reg;
    logic [MICRO_W-1:0]    a_us_reg;
    logic signed [S-1:0]   b_sec_reg;
    logic [MICRO_W-1:0]    b_us_reg;
    logic [F-1:0]          in_fac_reg;

    // total microseconds
    logic                  t_vld_reg;
    kind_t                 t_kind_reg;
    logic signed [TW-1:0]  ta_reg;
    logic signed [TW-1:0]  tb_reg;
    logic [F-1:0]          t_fac_reg;
    logic signed [TW-1:0]  a_sx;
    logic signed [TW-1:0]  b_sx;
    logic signed [TW-1:0]  ta_next;
    logic signed [TW-1:0]  tb_next;

    // sum, difference and compare
    logic                  v_vld_reg;
    kind_t                 v_kind_reg;
    logic signed [TW-1:0]  val_reg;
    logic                  v_lt_reg;
    logic                  v_eq_reg;
    logic [F-1:0]          v_fac_reg;
    logic signed [TW-1:0]  val_next;

    // magnitude and operand select
    logic                  g_vld_reg;
    ctl_t                  g_ctl_reg;
    logic [MAG_W-1:0]      g_mag_reg;
    logic [F-1:0]          g_mult_reg;
    logic [F-1:0]          g_dvs_reg;
    ctl_t                  g_ctl_next;
    logic [TW-1:0]         mag_full;

    logic                  dv_vld;
    ctl_t                  dv_ctl;
    logic [MAG_W-1:0]      dv_quo;
    logic [F-1:0]          dv_mult;
    logic                  mu_vld;
    ctl_t                  mu_ctl;
    logic [PW-1:0]         mu_prod;
    logic                  sp_vld;
    ctl_t                  sp_ctl;
    logic signed [QW:0]    sp_sec;
    logic [MICRO_W-1:0]    sp_us;

    // result, output and skid stages
    logic                  res_vld_reg;
    logic [RW-1:0]         res_reg;
    logic [RW-1:0]         res_next;
    logic                  arith;
    logic                  ovf;
    logic                  out_vld_reg;
    logic [RW-1:0]         out_reg;
    logic                  skid_vld_reg;
    logic [RW-1:0]         skid_reg;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            t_vld_reg  <= 1'b0;
            v_vld_reg  <= 1'b0;
            g_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            in_vld_reg <= s_tvalid;
            t_vld_reg  <= in_vld_reg;
            v_vld_reg  <= t_vld_reg;
            g_vld_reg  <= v_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_kind_reg <= kind_t'(s_tuser);
            a_sec_reg   <= s_tdata[S-1:0];
            a_us_reg    <= s_tdata[S+MICRO_W-1:S];
            b_sec_reg   <= s_tdata[2*S+MICRO_W-1:S+MICRO_W];
            b_us_reg    <= s_tdata[2*S+2*MICRO_W-1:2*S+MICRO_W];
            in_fac_reg  <= s_tdata[2*S+2*MICRO_W+F-1:2*S+2*MICRO_W];
        end
    end

    // seconds times one million plus microseconds
    always_comb
    begin
        a_sx    = TW'(a_sec_reg);
        b_sx    = TW'(b_sec_reg);
        ta_next = a_sx * $signed({1'b0, MICROS_PER_SEC}) + $signed({1'b0, a_us_reg});
        tb_next = b_sx * $signed({1'b0, MICROS_PER_SEC}) + $signed({1'b0, b_us_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_kind_reg <= in_kind_reg;
            ta_reg     <= ta_next;
            tb_reg     <= tb_next;
            t_fac_reg  <= in_fac_reg;
        end
    end

    // add, subtract or pass A; compare A against B
    always_comb
    begin
        unique case (t_kind_reg)
            KIND_ADD: val_next = ta_reg + tb_reg;
            KIND_SUB: val_next = ta_reg - tb_reg;
            default:  val_next = ta_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_kind_reg <= t_kind_reg;
            val_reg    <= val_next;
            v_lt_reg   <= ta_reg < tb_reg;
            v_eq_reg   <= ta_reg == tb_reg;
            v_fac_reg  <= t_fac_reg;
        end
    end

    // sign and magnitude, multiplier and divisor choice
    always_comb
    begin
        mag_full        = val_reg[TW-1] ? -val_reg : val_reg;
        g_ctl_next.kind = v_kind_reg;
        g_ctl_next.neg  = val_reg[TW-1];
        g_ctl_next.lt   = v_lt_reg;
        g_ctl_next.eq   = v_eq_reg;
        g_ctl_next.gt   = !v_lt_reg && !v_eq_reg;
        g_ctl_next.dz   = (v_kind_reg == KIND_DIV) && (v_fac_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_ctl_reg  <= g_ctl_next;
            g_mag_reg  <= mag_full[MAG_W-1:0];
            g_mult_reg <= (v_kind_reg == KIND_MUL) ? v_fac_reg : F'(1);
            g_dvs_reg  <= ((v_kind_reg == KIND_DIV) && (v_fac_reg != '0)) ? v_fac_reg : F'(1);
        end
    end

    tsa_div #(
        .MAG_W       (MAG_W),
        .FACTOR_BITS (F)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_vld_reg),
        .in_ctl    (g_ctl_reg),
        .in_mag    (g_mag_reg),
        .in_mult   (g_mult_reg),
        .in_dvs    (g_dvs_reg),
        .out_valid (dv_vld),
        .out_ctl   (dv_ctl),
        .out_quo   (dv_quo),
        .out_mult  (dv_mult)
    );

    tsa_mul #(
        .MAG_W       (MAG_W),
        .FACTOR_BITS (F)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_vld),
        .in_ctl    (dv_ctl),
        .in_mag    (dv_quo),
        .in_mult   (dv_mult),
        .out_valid (mu_vld),
        .out_ctl   (mu_ctl),
        .out_prod  (mu_prod)
    );

    tsa_split #(
        .PW (PW)
    ) u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mu_vld),
        .in_ctl    (mu_ctl),
        .in_prod   (mu_prod),
        .out_valid (sp_vld),
        .out_ctl   (sp_ctl),
        .out_sec   (sp_sec),
        .out_micro (sp_us)
    );

    // result fields by kind
    always_comb
    begin
        unique case (sp_ctl.kind)
            KIND_ADD: arith = 1'b1;
            KIND_SUB: arith = 1'b1;
            KIND_MUL: arith = 1'b1;
            KIND_DIV: arith = !sp_ctl.dz;
            default:  arith = 1'b0;
        endcase
        ovf = arith && !((&sp_sec[QW:S-1]) || !(|sp_sec[QW:S-1]));
        res_next = {
            (sp_ctl.kind == KIND_DIV) && sp_ctl.dz,
            ovf,
            (sp_ctl.kind == KIND_CMP) && sp_ctl.gt,
            (sp_ctl.kind == KIND_CMP) && sp_ctl.eq,
            (sp_ctl.kind == KIND_CMP) && sp_ctl.lt,
            arith ? sp_us : {MICRO_W{1'b0}},
            arith ? sp_sec[S-1:0] : {S{1'b0}}
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            res_vld_reg <= sp_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    // output register with one skid beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (m_tready || !out_vld_reg)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= res_vld_reg;
            end
        end
        else if (res_vld_reg && en)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_vld_reg)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res_reg;
        end
        else if (en)
        begin
            skid_reg <= res_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_DW'(out_reg);

    `TSA_ASSERT_IMPL(a_skid_needs_out, skid_vld_reg, out_vld_reg)
    `TSA_ASSERT_IMPL(a_skid_on_stall, $rose(skid_vld_reg), $past(out_vld_reg && !m_tready))
    `TSA_ASSERT_IMPL(a_cmp_onehot, out_vld_reg, $onehot0(out_reg[FLG+2:FLG]))
    `TSA_ASSERT_IMPL(a_micro_range, out_vld_reg, out_reg[FLG-1:S] < MICROS_PER_SEC)
    `TSA_ASSERT_IMPL(a_flag_excl, out_vld_reg && out_reg[FLG+4], out_reg[FLG+3:FLG] == 4'b0000)

endmodule

`default_nettype wire
